// ===== design/lfu_frame_replacement_unit_defines.svh =====
// ----------------------------------------------------------------------------
// LFU frame replacement unit: assertion macros
// Shared property forms for the checks inside the unit.
// ----------------------------------------------------------------------------
`ifndef LFU_FRAME_REPLACEMENT_UNIT_DEFINES_SVH
`define LFU_FRAME_REPLACEMENT_UNIT_DEFINES_SVH

// Condition must hold at every edge outside reset.
`define LFU_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define LFU_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define LFU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// LFU frame replacement package
// Fixed field widths, action and result codes, and the result beat type.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

   localparam int STAMP_W     = 32;
   localparam int FRAME_CFG_W = 6;
   localparam int ITEM_ID_W   = 7;

   localparam logic [FRAME_CFG_W-1:0] FRAME_COUNT_RESET = 6'd3;

   localparam logic ACT_RECOMMEND = 1'b0;
   localparam logic ACT_LIST      = 1'b1;

   localparam logic KIND_RECOMMEND = 1'b0;
   localparam logic KIND_LIST      = 1'b1;

   typedef struct packed {
      logic                 kind;
      logic [ITEM_ID_W-1:0] item_id;
      logic                 was_held;
      logic                 evicted;
      logic                 present;
      logic                 last;
   } rsp_beat_type;

endpackage

`default_nettype wire

// ===== design/lfu_frame_replacement_unit.sv =====
// Usage: LFU frame keeper with oldest-insertion tie-break.
// Input beats (req_*) carry an action and a candidate id; result beats (rsp_*)
// carry one response per recommend, or one beat per held id for a listing.
// Both channels use valid/stall; the unit raises req_stall while it works on
// an item, so one item is in flight at a time.
// A hit or an insert into a free frame goes through the lookup and response
// states before rsp_valid rises; the next item is taken after that.
// An eviction scans the whole id store, one entry read per cycle from the
// entry memory, then goes through the evict, insert and response states.
// A listing scans the entries in order and ends with the beat of its last
// held id; it pauses while rsp_stall holds a beat. An empty listing answers
// from the response state. A result also waits while rsp_stall holds
// an earlier beat in the output register.
// After reset the unit clears the entry memory, one entry per cycle, with
// req_stall high until every entry is clear; csr writes are taken
// at any time and set the frame count (reset value 3).
// A stalled result stays in the output register; the scan of a listing
// pauses and rereads its current entry until the beat moves.
// Memory accesses never overlap: each read-modify-write finishes before the
// next item is accepted.
// ----------------------------------------------------------------------------
// LFU frame replacement unit
// Tracks hit counts and insertion stamps of held ids and picks eviction victims.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lfu_frame_replacement_unit_defines.svh"

module lfu_frame_replacement_unit #(
   parameter int ID_RANGE    = 128,
   parameter int MAX_FRAMES  = 32,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_write_enable,
   input  wire logic [lfu_pkg::FRAME_CFG_W-1:0]   csr_write_data,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_action,
   input  wire logic [lfu_pkg::ITEM_ID_W-1:0]     req_candidate_id,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_kind,
   output logic [lfu_pkg::ITEM_ID_W-1:0]          rsp_item_id,
   output logic                                   rsp_was_held,
   output logic                                   rsp_evicted,
   output logic                                   rsp_present,
   output logic                                   rsp_last
);

   localparam int ID_W    = $clog2(ID_RANGE);
   localparam int SCAN_W  = ID_W + 1;
   localparam int HT_W    = $clog2(MAX_FRAMES + 1);
   localparam int ENTRY_W = COUNT_WIDTH + lfu_pkg::STAMP_W;
   localparam int WIDE_W  = ID_W + lfu_pkg::ITEM_ID_W;
   localparam int CAND_N  = 2 ** lfu_pkg::ITEM_ID_W;

   localparam logic [ID_W-1:0]        ID_LAST      = ID_W'(ID_RANGE - 1);
   localparam logic [SCAN_W-1:0]      SCAN_END     = SCAN_W'(ID_RANGE);
   localparam logic [7:0]             MAX_FRAMES_L = 8'(MAX_FRAMES);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX    = '1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE    = COUNT_WIDTH'(1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN,
      ST_EVICT,
      ST_INSERT,
      ST_RESP
   } state_type;

   state_type                       state_ff, state_in;
   logic [ID_W-1:0]                 clr_idx_ff, clr_idx_in;
   logic [lfu_pkg::FRAME_CFG_W-1:0] frame_count_ff, frame_count_in;
   logic [HT_W-1:0]                 held_total_ff, held_total_in;
   logic [lfu_pkg::STAMP_W-1:0]     seq_ff, seq_in;
   logic [ID_W-1:0]                 cur_id_ff, cur_id_in;
   logic                            is_list_ff, is_list_in;
   logic [SCAN_W-1:0]               next_idx_ff, next_idx_in;
   logic                            eval_valid_ff, eval_valid_in;
   logic [ID_W-1:0]                 eval_idx_ff, eval_idx_in;
   logic [HT_W-1:0]                 emit_cnt_ff, emit_cnt_in;
   logic                            found_ff, found_in;
   logic [ID_W-1:0]                 best_idx_ff, best_idx_in;
   logic [COUNT_WIDTH-1:0]          best_count_ff, best_count_in;
   logic [lfu_pkg::STAMP_W-1:0]     best_stamp_ff, best_stamp_in;
   lfu_pkg::rsp_beat_type           pend_ff, pend_in;
   lfu_pkg::rsp_beat_type           rsp_ff, rsp_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   logic [ENTRY_W-1:0]              entry_mem [ID_RANGE];
   logic [ENTRY_W-1:0]              rd_data_ff;
   logic [ID_W-1:0]                 rd_addr;
   logic                            mem_we;
   logic [ID_W-1:0]                 mem_waddr;
   logic [ENTRY_W-1:0]              mem_wdata;

   logic [ID_W-1:0]                 id_fold [CAND_N];
   logic [COUNT_WIDTH-1:0]          rd_count;
   logic [lfu_pkg::STAMP_W-1:0]     rd_stamp;
   logic [7:0]                      frame_count_w;
   logic [7:0]                      frame_limit;
   logic                            out_free;
   logic                            scan_issue;
   logic                            scan_held;
   logic                            scan_blocked;
   logic                            list_last;
   logic                            rsp_load;
   lfu_pkg::rsp_beat_type           rsp_beat;
   logic [WIDE_W-1:0]               best_wide;
   logic [WIDE_W-1:0]               eval_wide;

   // Candidate id folded into the id space.
   for (genvar g = 0; g < CAND_N; g++) begin : g_fold
      assign id_fold[g] = ID_W'(g % ID_RANGE);
   end

   // Entry layout: {insertion stamp, hit count}; a zero count means free.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   assign rd_count  = rd_data_ff[COUNT_WIDTH-1:0];
   assign rd_stamp  = rd_data_ff[ENTRY_W-1:COUNT_WIDTH];
   assign best_wide = WIDE_W'(best_idx_ff);
   assign eval_wide = WIDE_W'(eval_idx_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign frame_count_w = 8'(frame_count_ff);
   always_comb begin
      priority if (frame_count_w == 8'd0) begin
         frame_limit = 8'd1;
      end else if (frame_count_w > MAX_FRAMES_L) begin
         frame_limit = MAX_FRAMES_L;
      end else begin
         frame_limit = frame_count_w;
      end
   end

   assign scan_issue   = next_idx_ff < SCAN_END;
   assign scan_held    = eval_valid_ff && (rd_count != '0);
   assign scan_blocked = is_list_ff && scan_held && !out_free;
   assign list_last    = HT_W'(emit_cnt_ff + HT_W'(1)) == held_total_ff;

   always_comb begin
      state_in       = state_ff;
      clr_idx_in     = clr_idx_ff;
      frame_count_in = csr_write_enable ? csr_write_data : frame_count_ff;
      held_total_in  = held_total_ff;
      seq_in         = seq_ff;
      cur_id_in      = cur_id_ff;
      is_list_in     = is_list_ff;
      next_idx_in    = next_idx_ff;
      eval_valid_in  = eval_valid_ff;
      eval_idx_in    = eval_idx_ff;
      emit_cnt_in    = emit_cnt_ff;
      found_in       = found_ff;
      best_idx_in    = best_idx_ff;
      best_count_in  = best_count_ff;
      best_stamp_in  = best_stamp_ff;
      pend_in        = pend_ff;
      rd_addr        = '0;
      mem_we         = 1'b0;
      mem_waddr      = cur_id_ff;
      mem_wdata      = '0;
      rsp_load       = 1'b0;
      rsp_beat       = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_idx_ff;
            clr_idx_in = ID_W'(clr_idx_ff + ID_W'(1));
            if (clr_idx_ff == ID_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            rd_addr = id_fold[req_candidate_id];
            if (req_valid) begin
               cur_id_in     = id_fold[req_candidate_id];
               is_list_in    = req_action == lfu_pkg::ACT_LIST;
               next_idx_in   = '0;
               eval_valid_in = 1'b0;
               emit_cnt_in   = '0;
               found_in      = 1'b0;
               if (req_action == lfu_pkg::ACT_LIST) begin
                  if (held_total_ff == '0) begin
                     pend_in      = '0;
                     pend_in.kind = lfu_pkg::KIND_LIST;
                     pend_in.last = 1'b1;
                     state_in     = ST_RESP;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else begin
                  seq_in   = seq_ff + 32'd1;
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            pend_in      = '0;
            pend_in.kind = lfu_pkg::KIND_RECOMMEND;
            pend_in.last = 1'b1;
            if (rd_count != '0) begin
               // Hit: bump the count, saturate at the top, keep the stamp.
               mem_we           = 1'b1;
               mem_wdata        = {rd_stamp,
                                   (rd_count == COUNT_MAX) ? rd_count
                                                           : rd_count + COUNT_ONE};
               pend_in.was_held = 1'b1;
               state_in         = ST_RESP;
            end else if (8'(held_total_ff) < frame_limit) begin
               mem_we        = 1'b1;
               mem_wdata     = {seq_ff, COUNT_ONE};
               held_total_in = HT_W'(held_total_ff + HT_W'(1));
               state_in      = ST_RESP;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_blocked) begin
               // Reread the pending entry until the output register frees up.
               rd_addr = eval_idx_ff;
            end else begin
               rd_addr       = scan_issue ? next_idx_ff[ID_W-1:0] : '0;
               eval_idx_in   = next_idx_ff[ID_W-1:0];
               eval_valid_in = scan_issue;
               if (scan_issue) begin
                  next_idx_in = next_idx_ff + SCAN_W'(1);
               end
               if (is_list_ff) begin
                  if (scan_held) begin
                     rsp_load         = 1'b1;
                     rsp_beat.kind    = lfu_pkg::KIND_LIST;
                     rsp_beat.item_id = eval_wide[lfu_pkg::ITEM_ID_W-1:0];
                     rsp_beat.present = 1'b1;
                     rsp_beat.last    = list_last;
                     emit_cnt_in      = HT_W'(emit_cnt_ff + HT_W'(1));
                     if (list_last) begin
                        state_in = ST_IDLE;
                     end
                  end
               end else if (scan_held && (!found_ff || rd_count < best_count_ff ||
                            (rd_count == best_count_ff && rd_stamp < best_stamp_ff))) begin
                  found_in      = 1'b1;
                  best_idx_in   = eval_idx_ff;
                  best_count_in = rd_count;
                  best_stamp_in = rd_stamp;
               end
               if (eval_valid_ff && eval_idx_ff == ID_LAST) begin
                  state_in = is_list_ff ? ST_IDLE : ST_EVICT;
               end
            end
         end
         ST_EVICT: begin
            if (found_ff) begin
               mem_we    = 1'b1;
               mem_waddr = best_idx_ff;
            end else begin
               held_total_in = HT_W'(held_total_ff + HT_W'(1));
            end
            state_in = ST_INSERT;
         end
         ST_INSERT: begin
            mem_we           = 1'b1;
            mem_wdata        = {seq_ff, COUNT_ONE};
            pend_in          = '0;
            pend_in.kind     = lfu_pkg::KIND_RECOMMEND;
            pend_in.item_id  = found_ff ? best_wide[lfu_pkg::ITEM_ID_W-1:0] : '0;
            pend_in.evicted  = found_ff;
            pend_in.last     = 1'b1;
            state_in         = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_load = 1'b1;
               rsp_beat = pend_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_in       = rsp_load ? rsp_beat : rsp_ff;
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_idx_ff     <= '0;
         frame_count_ff <= lfu_pkg::FRAME_COUNT_RESET;
         held_total_ff  <= '0;
         seq_ff         <= '0;
         eval_valid_ff  <= 1'b0;
         found_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_idx_ff     <= clr_idx_in;
         frame_count_ff <= frame_count_in;
         held_total_ff  <= held_total_in;
         seq_ff         <= seq_in;
         eval_valid_ff  <= eval_valid_in;
         found_ff       <= found_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cur_id_ff     <= cur_id_in;
      is_list_ff    <= is_list_in;
      next_idx_ff   <= next_idx_in;
      eval_idx_ff   <= eval_idx_in;
      emit_cnt_ff   <= emit_cnt_in;
      best_idx_ff   <= best_idx_in;
      best_count_ff <= best_count_in;
      best_stamp_ff <= best_stamp_in;
      pend_ff       <= pend_in;
      rsp_ff        <= rsp_in;
   end

   assign req_stall    = state_ff != ST_IDLE;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_ff.kind;
   assign rsp_item_id  = rsp_ff.item_id;
   assign rsp_was_held = rsp_ff.was_held;
   assign rsp_evicted  = rsp_ff.evicted;
   assign rsp_present  = rsp_ff.present;
   assign rsp_last     = rsp_ff.last;

   `LFU_ASSERT_ALWAYS(a_held_bound, clock, reset, 8'(held_total_ff) <= MAX_FRAMES_L, "held total above frame maximum")
   `LFU_ASSERT_IMPL(a_no_write_in_scan, clock, reset, state_ff == ST_SCAN, !mem_we, "memory write during scan")
   `LFU_ASSERT_IMPL(a_evict_has_victim, clock, reset, state_ff == ST_EVICT, found_ff, "eviction without a victim")
   `LFU_ASSERT_NEXT(a_last_ends_list, clock, reset, rsp_load && rsp_beat.kind == lfu_pkg::KIND_LIST && rsp_beat.last, state_ff == ST_IDLE, "listing continues after last beat")
   `LFU_ASSERT_IMPL(a_evict_not_held, clock, reset, rsp_valid_ff && rsp_ff.evicted, !rsp_ff.was_held, "evicted beat marked as held")

endmodule

`default_nettype wire

// ===== verif/lfu_frame_replacement_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU frame replacement checker
// Watches the request, result and csr ports of the unit. Keeps its own copy
// of the hit counts, insertion stamps and frame setting, computes the beats
// each accepted request must produce, and compares every result beat in order.
// ----------------------------------------------------------------------------
module lfu_frame_replacement_checker #(
   parameter int ID_RANGE    = 128,
   parameter int MAX_FRAMES  = 32,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_enable,
   input  wire logic [lfu_pkg::FRAME_CFG_W-1:0] csr_write_data,
   input  wire logic                            req_valid,
   input  wire logic                            req_stall,
   input  wire logic                            req_action,
   input  wire logic [lfu_pkg::ITEM_ID_W-1:0]   req_candidate_id,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   input  wire logic                            rsp_kind,
   input  wire logic [lfu_pkg::ITEM_ID_W-1:0]   rsp_item_id,
   input  wire logic                            rsp_was_held,
   input  wire logic                            rsp_evicted,
   input  wire logic                            rsp_present,
   input  wire logic                            rsp_last,
   output int                                   fail_count,
   output int                                   pending_beats,
   output int                                   beats_checked,
   output int                                   evictions_seen
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);

   logic [COUNT_WIDTH-1:0]          hit_count [ID_RANGE];
   logic [lfu_pkg::STAMP_W-1:0]     insert_stamp [ID_RANGE];
   int unsigned                     held_total;
   logic [lfu_pkg::STAMP_W-1:0]     sequence_number;
   logic [lfu_pkg::FRAME_CFG_W-1:0] frame_count;
   lfu_pkg::rsp_beat_type           awaited_beats [$];

   initial begin
      fail_count     = 0;
      pending_beats  = 0;
      beats_checked  = 0;
      evictions_seen = 0;
   end

   function automatic int unsigned frame_limit();
      if (frame_count == 0) begin
         return 1;
      end
      if (frame_count > MAX_FRAMES) begin
         return MAX_FRAMES;
      end
      return 32'(frame_count);
   endfunction

   function automatic lfu_pkg::rsp_beat_type make_beat(logic kind,
                                                       logic [lfu_pkg::ITEM_ID_W-1:0] id,
                                                       logic was_held, logic evicted,
                                                       logic present, logic last);
      lfu_pkg::rsp_beat_type beat;
      beat.kind     = kind;
      beat.item_id  = id;
      beat.was_held = was_held;
      beat.evicted  = evicted;
      beat.present  = present;
      beat.last     = last;
      return beat;
   endfunction

   function automatic void apply_recommend(logic [lfu_pkg::ITEM_ID_W-1:0] id);
      int unsigned slot;
      int unsigned victim;
      bit          found;
      int          i;
      slot = id % ID_RANGE;
      sequence_number = sequence_number + 1'b1;
      if (hit_count[slot] != 0) begin
         // saturate, never wrap back to "not held"
         if (hit_count[slot] != COUNT_MAX) begin
            hit_count[slot] = hit_count[slot] + 1'b1;
         end
         awaited_beats.push_back(make_beat(lfu_pkg::KIND_RECOMMEND, '0, 1'b1, 1'b0,
                                           1'b0, 1'b1));
      end else if (held_total < frame_limit()) begin
         hit_count[slot]    = COUNT_ONE;
         insert_stamp[slot] = sequence_number;
         held_total++;
         awaited_beats.push_back(make_beat(lfu_pkg::KIND_RECOMMEND, '0, 1'b0, 1'b0,
                                           1'b0, 1'b1));
      end else begin
         found  = 1'b0;
         victim = 0;
         for (i = 0; i < ID_RANGE; i++) begin
            if (hit_count[i] != 0 &&
                (!found || hit_count[i] < hit_count[victim] ||
                 (hit_count[i] == hit_count[victim] &&
                  insert_stamp[i] < insert_stamp[victim]))) begin
               victim = i;
               found  = 1'b1;
            end
         end
         if (found) begin
            hit_count[victim] = '0;
         end else begin
            held_total++;
         end
         hit_count[slot]    = COUNT_ONE;
         insert_stamp[slot] = sequence_number;
         awaited_beats.push_back(make_beat(lfu_pkg::KIND_RECOMMEND,
                                           found ? lfu_pkg::ITEM_ID_W'(victim) : '0,
                                           1'b0, found, 1'b0, 1'b1));
      end
   endfunction

   function automatic void apply_listing();
      int total;
      int n;
      int i;
      total = 0;
      for (i = 0; i < ID_RANGE; i++) begin
         if (hit_count[i] != 0) begin
            total++;
         end
      end
      if (total > MAX_FRAMES) begin
         total = MAX_FRAMES;
      end
      if (total == 0) begin
         awaited_beats.push_back(make_beat(lfu_pkg::KIND_LIST, '0, 1'b0, 1'b0, 1'b0,
                                           1'b1));
      end else begin
         n = 0;
         for (i = 0; i < ID_RANGE && n < total; i++) begin
            if (hit_count[i] != 0) begin
               awaited_beats.push_back(make_beat(lfu_pkg::KIND_LIST,
                                                 lfu_pkg::ITEM_ID_W'(i), 1'b0, 1'b0,
                                                 1'b1, n == total - 1));
               n++;
            end
         end
      end
   endfunction

   function automatic void compare_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic void check_beat();
      lfu_pkg::rsp_beat_type want;
      if (awaited_beats.size() == 0) begin
         $error("result beat with nothing awaited: kind %0d item_id %0d",
                rsp_kind, rsp_item_id);
         fail_count++;
      end else begin
         want = awaited_beats.pop_front();
         compare_field("kind", want.kind, rsp_kind);
         compare_field("item_id", want.item_id, rsp_item_id);
         compare_field("was_held", want.was_held, rsp_was_held);
         compare_field("evicted", want.evicted, rsp_evicted);
         compare_field("present", want.present, rsp_present);
         compare_field("last", want.last, rsp_last);
         beats_checked++;
         if (want.evicted) begin
            evictions_seen++;
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ID_RANGE; i++) begin
            hit_count[i]    = '0;
            insert_stamp[i] = '0;
         end
         held_total      = 0;
         sequence_number = '0;
         frame_count     = lfu_pkg::FRAME_COUNT_RESET;
         awaited_beats.delete();
      end else begin
         if (csr_write_enable) begin
            frame_count = csr_write_data;
         end
         if (rsp_valid && !rsp_stall) begin
            check_beat();
         end
         if (req_valid && !req_stall) begin
            if (req_action == lfu_pkg::ACT_LIST) begin
               apply_listing();
            end else begin
               apply_recommend(req_candidate_id);
            end
         end
      end
      pending_beats = awaited_beats.size();
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LFU frame replacement unit testbench
// Drives recommend and list requests through the frame settings, with random
// gaps on both channels, a gap-free hit burst and pauses for the unit to
// drain; the checker beside the unit predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 160;
   localparam int SETTLE_CYCLES  = 8;
   localparam int BURST_HITS     = 30;
   localparam int PHASE_ITEMS    = 28;
   localparam int MAX_FRAMES     = 32;

   logic                            clock            = 1'b0;
   logic                            reset            = 1'b1;
   logic                            csr_write_enable = 1'b0;
   logic [lfu_pkg::FRAME_CFG_W-1:0] csr_write_data   = '0;
   logic                            req_valid        = 1'b0;
   logic                            req_action       = lfu_pkg::ACT_RECOMMEND;
   logic [lfu_pkg::ITEM_ID_W-1:0]   req_candidate_id = '0;
   logic                            rsp_stall        = 1'b0;

   wire logic                          req_stall;
   wire logic                          rsp_valid;
   wire logic                          rsp_kind;
   wire logic [lfu_pkg::ITEM_ID_W-1:0] rsp_item_id;
   wire logic                          rsp_was_held;
   wire logic                          rsp_evicted;
   wire logic                          rsp_present;
   wire logic                          rsp_last;

   int fail_count;
   int pending_beats;
   int beats_checked;
   int evictions_seen;
   int requests_sent = 0;
   int listings_sent = 0;
   int idle_cycles   = 0;
   int leftover;
   bit quiet = 1'b0;

   logic [lfu_pkg::FRAME_CFG_W-1:0] phase_cfg [9] = '{6'd63, 6'd32, 6'd1, 6'd0, 6'd16,
                                                       6'd33, 6'd2, 6'd11, 6'd5};

   always #4 clock = ~clock;

   lfu_frame_replacement_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_candidate_id (req_candidate_id),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_item_id      (rsp_item_id),
      .rsp_was_held     (rsp_was_held),
      .rsp_evicted      (rsp_evicted),
      .rsp_present      (rsp_present),
      .rsp_last         (rsp_last)
   );

   lfu_frame_replacement_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_candidate_id (req_candidate_id),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_item_id      (rsp_item_id),
      .rsp_was_held     (rsp_was_held),
      .rsp_evicted      (rsp_evicted),
      .rsp_present      (rsp_present),
      .rsp_last         (rsp_last),
      .fail_count       (fail_count),
      .pending_beats    (pending_beats),
      .beats_checked    (beats_checked),
      .evictions_seen   (evictions_seen)
   );

   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 7);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Enter and leave at a falling edge; valid stays high after the beat.
   task automatic send_item(input logic action, input logic [lfu_pkg::ITEM_ID_W-1:0] id);
      while (!quiet && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= action;
      req_candidate_id <= id;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      @(negedge clock);
      requests_sent++;
      if (action == lfu_pkg::ACT_LIST) begin
         listings_sent++;
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_beats != 0) begin
         @(negedge clock);
      end
   endtask

   // Frame count changes only with the unit drained and settled.
   task automatic set_frame_count(input logic [lfu_pkg::FRAME_CFG_W-1:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_phase(input logic [lfu_pkg::FRAME_CFG_W-1:0] cfg);
      int span;
      int base;
      int roll;
      set_frame_count(cfg);
      span = (cfg == 0) ? 1 : (cfg > MAX_FRAMES) ? MAX_FRAMES : cfg;
      span = span + 2;
      base = $urandom_range(0, 127);
      repeat (PHASE_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 12) begin
            send_item(lfu_pkg::ACT_LIST, lfu_pkg::ITEM_ID_W'($urandom_range(0, 127)));
         end else if (roll < 75) begin
            // a pool just past the frame count keeps hits and evictions coming
            send_item(lfu_pkg::ACT_RECOMMEND,
                      lfu_pkg::ITEM_ID_W'(base + $urandom_range(0, span - 1)));
         end else begin
            send_item(lfu_pkg::ACT_RECOMMEND,
                      lfu_pkg::ITEM_ID_W'($urandom_range(0, 127)));
         end
      end
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // frame count at its reset value of three
      send_item(lfu_pkg::ACT_LIST, 7'd0);
      send_item(lfu_pkg::ACT_RECOMMEND, 7'd0);
      send_item(lfu_pkg::ACT_RECOMMEND, 7'd127);
      send_item(lfu_pkg::ACT_RECOMMEND, 7'd0);
      send_item(lfu_pkg::ACT_RECOMMEND, 7'd64);
      send_item(lfu_pkg::ACT_RECOMMEND, 7'd42);
      send_item(lfu_pkg::ACT_LIST, 7'd127);
      send_item(lfu_pkg::ACT_RECOMMEND, 7'd127);
      send_item(lfu_pkg::ACT_RECOMMEND, 7'd42);

      // drop below the held total: each new id swaps one out
      set_frame_count(6'd1);
      send_item(lfu_pkg::ACT_RECOMMEND, 7'd100);
      send_item(lfu_pkg::ACT_RECOMMEND, 7'd101);
      send_item(lfu_pkg::ACT_LIST, 7'd0);

      set_frame_count(6'd0);
      send_item(lfu_pkg::ACT_RECOMMEND, 7'h55);
      send_item(lfu_pkg::ACT_RECOMMEND, 7'h2A);
      send_item(lfu_pkg::ACT_LIST, 7'h55);

      set_frame_count(6'd63);
      send_item(lfu_pkg::ACT_RECOMMEND, 7'd1);
      send_item(lfu_pkg::ACT_RECOMMEND, 7'd126);
      send_item(lfu_pkg::ACT_RECOMMEND, 7'd63);
      send_item(lfu_pkg::ACT_LIST, 7'd0);

      // hammer one id back to back with no gaps on either side
      wait_drained();
      quiet = 1'b1;
      repeat (BURST_HITS) send_item(lfu_pkg::ACT_RECOMMEND, 7'd126);
      send_item(lfu_pkg::ACT_RECOMMEND, 7'd126);
      send_item(lfu_pkg::ACT_LIST, 7'd0);
      wait_drained();
      quiet = 1'b0;

      for (int p = 0; p < 9; p++) begin
         if (p == 7) begin
            phase_cfg[p] = lfu_pkg::FRAME_CFG_W'($urandom_range(3, 31));
         end
         quiet = (p == 2);
         run_phase(phase_cfg[p]);
      end
      quiet = 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      leftover = pending_beats;
      if (leftover != 0) begin
         $error("%0d result beats never arrived", leftover);
      end
      $display("covered %0d requests (%0d listings), frame counts from 0 to 63, hit burst",
               requests_sent, listings_sent);
      $display("checked %0d result beats, %0d of them evictions",
               beats_checked, evictions_seen);
      if (fail_count == 0 && leftover == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/lfu_pkg.sv
design/lfu_frame_replacement_unit.sv
verif/lfu_frame_replacement_checker.sv
verif/testbench.sv
